// File: hw/rtl/median_pressure_relief_control_unit_assert.svh
// Assertion helpers shared by the RTL modules.
// Each module that asserts names its clock clk and its reset arst_n.
`ifndef MEDIAN_PRESSURE_RELIEF_CONTROL_UNIT_ASSERT_SVH
`define MEDIAN_PRESSURE_RELIEF_CONTROL_UNIT_ASSERT_SVH

// cond holds -> prop holds in the same cycle
`define MPRC_ASSERT_NOW(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("mprc assertion failed");

// cond holds -> prop holds in the next cycle
`define MPRC_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("mprc assertion failed");

`endif

// File: hw/rtl/mprc_pkg.sv
package mprc_pkg;

	// frame_length register is 4 bits, so a frame never holds more than this
	localparam int FRAME_MAX       = 15;
	localparam int MAX_SAMPLES_DEF = 15;
	localparam int ADC_BITS_DEF    = 12;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int MV_SHIFT        = 12;
	localparam int PR_SHIFT        = 16;

	localparam logic [3:0]  FRAME_LENGTH_RST = 4'd5;
	localparam logic [15:0] MV_PER_COUNT_RST = 16'd3300;
	localparam logic [15:0] OFFSET_MV_RST    = 16'd500;
	localparam logic [15:0] PSI_PER_MV_RST   = 16'd2048;
	localparam logic [15:0] LIMIT_RST        = 16'd1500;
	localparam logic [15:0] HYST_RST         = 16'd100;
	localparam logic [31:0] TIMEOUT_RST      = 32'd600000;

	typedef enum logic [1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_OVERRIDE = 2'd1,
		CMD_TICK     = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_LENGTH = 3'd0,
		REG_MV_PER_COUNT = 3'd1,
		REG_OFFSET_MV    = 3'd2,
		REG_PSI_PER_MV   = 3'd3,
		REG_LIMIT        = 3'd4,
		REG_HYSTERESIS   = 3'd5,
		REG_TIMEOUT      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0]  frame_length;
		logic [15:0] mv_per_count;
		logic [15:0] sensor_offset_mv;
		logic [15:0] psi_per_mv;
		logic [15:0] pressure_limit;
		logic [15:0] pressure_hysteresis;
		logic [31:0] override_timeout;
	} cfg_t;

	typedef struct packed {
		logic active;
		logic forced;
	} ovr_t;

	typedef enum logic {
		F_ACCEPT,
		F_SEARCH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_VOLT,
		B_PRES,
		B_DEC
	} back_state_t;

endpackage

// File: hw/rtl/mprc_fifo.sv
`include "median_pressure_relief_control_unit_assert.svh"

module mprc_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = mprc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`MPRC_ASSERT_NOW(a_fifo_no_overrun, push, !full)
	`MPRC_ASSERT_NOW(a_fifo_no_underrun, pop, !empty)

endmodule

// File: hw/rtl/mprc_front.sv
`include "median_pressure_relief_control_unit_assert.svh"

module mprc_front #(
	parameter int MAX_SAMPLES = mprc_pkg::MAX_SAMPLES_DEF,
	parameter int ADC_BITS    = mprc_pkg::ADC_BITS_DEF,
	parameter int EW          = ADC_BITS + $bits(mprc_pkg::ovr_t)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mprc_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          command,
	input  logic [ADC_BITS-1:0] adc_sample,
	input  logic                manual_on,
	input  logic                q_full,
	output logic                q_push,
	output logic [EW-1:0]       q_data
);

	// only the first FRAME_MAX entries can ever be part of a frame
	localparam int NUSE  = (MAX_SAMPLES < mprc_pkg::FRAME_MAX) ? MAX_SAMPLES
		: mprc_pkg::FRAME_MAX;
	localparam int IDX_W = (NUSE > 1) ? $clog2(NUSE) : 1;
	localparam int LEN_W = $clog2(NUSE + 1);

	mprc_pkg::front_state_t state_q, state_d;

	logic [ADC_BITS-1:0] store_q [NUSE];
	logic [IDX_W-1:0]    idx_q, cand_q;
	logic [LEN_W-1:0]    len_q, len;
	logic [31:0]         tick_q, start_q;
	logic                ovr_flag_q, forced_q;

	logic                accept, frame_end, expired, found;
	logic [LEN_W:0]      idx_inc;
	logic [4:0]          n5;
	logic [ADC_BITS-1:0] cand_val;
	logic [NUSE-1:0]     rank_mask;
	logic [LEN_W-1:0]    rank;
	mprc_pkg::cmd_t      cmd;
	mprc_pkg::ovr_t      ovr;

	assign cmd = mprc_pkg::cmd_t'(command);

	// effective frame length: clamp to 1..NUSE, raise even to odd, cap again
	always_comb begin
		n5 = {1'b0, cfg.frame_length};
		if (n5 == 5'd0) begin
			n5 = 5'd1;
		end
		if (n5 > 5'(NUSE)) begin
			n5 = 5'(NUSE);
		end
		if (!n5[0]) begin
			n5 = n5 + 5'd1;
			if (n5 > 5'(NUSE)) begin
				n5 = 5'(NUSE);
			end
		end
		len = LEN_W'(n5);
	end

	assign accept    = push && !full;
	assign idx_inc   = (LEN_W + 1)'(idx_q) + (LEN_W + 1)'(1);
	assign frame_end = accept && (cmd == mprc_pkg::CMD_SAMPLE) && (idx_inc >= {1'b0, len});
	assign expired   = ovr_flag_q && ((tick_q - start_q) > cfg.override_timeout);

	// rank of the candidate in a stable ascending sort of the frame
	assign cand_val = store_q[cand_q];
	always_comb begin
		for (int j = 0; j < NUSE; j++) begin
			rank_mask[j] = ((LEN_W'(j) < len_q) && (store_q[j] < cand_val))
				|| ((IDX_W'(j) < cand_q) && (store_q[j] == cand_val));
		end
		rank = LEN_W'($countones(rank_mask));
	end

	assign found = (state_q == mprc_pkg::F_SEARCH) && (rank == (len_q >> 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			mprc_pkg::F_ACCEPT: begin
				if (frame_end) begin
					state_d = mprc_pkg::F_SEARCH;
				end
			end
			mprc_pkg::F_SEARCH: begin
				if (found) begin
					state_d = mprc_pkg::F_ACCEPT;
				end
			end
			default: state_d = mprc_pkg::F_ACCEPT;
		endcase
	end

	always_comb begin
		full   = 1'b1;
		q_push = 1'b0;
		case (state_q)
			mprc_pkg::F_ACCEPT: full = q_full;
			mprc_pkg::F_SEARCH: q_push = found;
			default: full = 1'b1;
		endcase
	end

	assign ovr    = '{active: ovr_flag_q, forced: forced_q};
	assign q_data = {ovr, cand_val};

	always_ff @(posedge clk) begin
		if (accept && cmd == mprc_pkg::CMD_SAMPLE) begin
			store_q[idx_q] <= adc_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mprc_pkg::F_ACCEPT;
			idx_q      <= '0;
			cand_q     <= '0;
			len_q      <= '0;
			tick_q     <= '0;
			start_q    <= '0;
			ovr_flag_q <= 1'b0;
			forced_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (cmd)
					mprc_pkg::CMD_SAMPLE: begin
						if (frame_end) begin
							idx_q  <= '0;
							len_q  <= len;
							cand_q <= '0;
							if (expired) begin
								ovr_flag_q <= 1'b0;
							end
						end else begin
							idx_q <= IDX_W'(idx_inc);
						end
					end
					mprc_pkg::CMD_OVERRIDE: begin
						ovr_flag_q <= 1'b1;
						forced_q   <= manual_on;
						start_q    <= tick_q;
					end
					mprc_pkg::CMD_TICK: tick_q <= tick_q + 32'd1;
					default: ;
				endcase
			end
			if (state_q == mprc_pkg::F_SEARCH && !found) begin
				cand_q <= cand_q + IDX_W'(1);
			end
		end
	end

	`MPRC_ASSERT_NOW(a_push_room, q_push, !q_full)
	`MPRC_ASSERT_NOW(a_cand_in_frame, state_q == mprc_pkg::F_SEARCH, LEN_W'(cand_q) < len_q)

endmodule

// File: hw/rtl/mprc_back.sv
`include "median_pressure_relief_control_unit_assert.svh"

module mprc_back #(
	parameter int ADC_BITS = mprc_pkg::ADC_BITS_DEF,
	parameter int EW       = ADC_BITS + $bits(mprc_pkg::ovr_t)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mprc_pkg::cfg_t      cfg,
	input  logic                q_empty,
	input  logic [EW-1:0]       q_data,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic [ADC_BITS-1:0] median_raw,
	output logic [15:0]         sensor_mv,
	output logic [15:0]         pressure,
	output logic                valve_open,
	output logic                override_active
);

	localparam int PW = ADC_BITS + 16;

	mprc_pkg::back_state_t state_q, state_d;

	logic [ADC_BITS-1:0] med_s1;
	mprc_pkg::ovr_t      ovr_s1;
	logic [15:0]         mv_s2, pr_s3;
	logic                valve_q, res_valid_q;
	logic [ADC_BITS-1:0] res_med_q;
	logic [15:0]         res_mv_q, res_pr_q;
	logic                res_ovr_q;

	logic                slot_free, res_write, valve_d;
	logic [PW-1:0]       prod_mv;
	logic [31:0]         mv_sh, prod_pr;
	logic [15:0]         mv_sat, diff, pr_val;

	assign slot_free = !res_valid_q || pop;

	assign prod_mv = PW'(med_s1) * PW'(cfg.mv_per_count);
	assign mv_sh   = 32'(prod_mv >> mprc_pkg::MV_SHIFT);
	assign mv_sat  = (|mv_sh[31:16]) ? 16'hFFFF : mv_sh[15:0];

	// max product >> 16 stays below 2^16, no saturation needed
	assign diff    = mv_s2 - cfg.sensor_offset_mv;
	assign prod_pr = 32'(diff) * 32'(cfg.psi_per_mv);
	assign pr_val  = (mv_s2 > cfg.sensor_offset_mv) ? 16'(prod_pr >> mprc_pkg::PR_SHIFT)
		: 16'd0;

	// override forces the valve; else open when pr > limit, close when pr < limit - hyst, done without going negative
	always_comb begin
		valve_d = valve_q;
		if (ovr_s1.active) begin
			valve_d = ovr_s1.forced;
		end else if (pr_s3 > cfg.pressure_limit) begin
			valve_d = 1'b1;
		end else if ((17'(pr_s3) + 17'(cfg.pressure_hysteresis)) < 17'(cfg.pressure_limit)) begin
			valve_d = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mprc_pkg::B_IDLE: begin
				if (!q_empty) begin
					state_d = mprc_pkg::B_VOLT;
				end
			end
			mprc_pkg::B_VOLT: state_d = mprc_pkg::B_PRES;
			mprc_pkg::B_PRES: state_d = mprc_pkg::B_DEC;
			mprc_pkg::B_DEC: begin
				if (slot_free) begin
					state_d = mprc_pkg::B_IDLE;
				end
			end
			default: state_d = mprc_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		res_write = 1'b0;
		case (state_q)
			mprc_pkg::B_IDLE: q_pop = !q_empty;
			mprc_pkg::B_DEC: res_write = slot_free;
			default: ;
		endcase
	end

	assign empty           = !res_valid_q;
	assign median_raw      = res_med_q;
	assign sensor_mv       = res_mv_q;
	assign pressure        = res_pr_q;
	assign valve_open      = valve_q;
	assign override_active = res_ovr_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			med_s1 <= q_data[ADC_BITS-1:0];
			ovr_s1 <= mprc_pkg::ovr_t'(q_data[EW-1:ADC_BITS]);
		end
		if (state_q == mprc_pkg::B_VOLT) begin
			mv_s2 <= mv_sat;
		end
		if (state_q == mprc_pkg::B_PRES) begin
			pr_s3 <= pr_val;
		end
		if (res_write) begin
			res_med_q <= med_s1;
			res_mv_q  <= mv_s2;
			res_pr_q  <= pr_s3;
			res_ovr_q <= ovr_s1.active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mprc_pkg::B_IDLE;
			valve_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_write) begin
				valve_q     <= valve_d;
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`MPRC_ASSERT_NEXT(a_forced_valve, res_write && ovr_s1.active, valve_q == ovr_s1.forced)

endmodule

// File: hw/rtl/median_pressure_relief_control_unit.sv
// Median-filtered pressure relief controller. Write push/command words: a sample
// word stores into the current frame, a tick word advances the millisecond count,
// an override word forces the valve until the timeout passes. The sample word that
// closes a frame yields one result word; the other words yield none. After a
// frame-closing word the front end holds full high while it searches for the median
// one candidate per cycle through the single rank comparator row; the back end then
// steps through its volt, pressure and decision states for the two scaling
// multipliers and the valve decision. A two-entry queue sits between the two, and a
// one-word output register lets the next word in while a result waits. No clearing
// pass after reset.
module median_pressure_relief_control_unit #(
	parameter int MAX_SAMPLES = mprc_pkg::MAX_SAMPLES_DEF,
	parameter int ADC_BITS    = mprc_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [mprc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mprc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      command,
	input  logic [ADC_BITS-1:0]             adc_sample,
	input  logic                            manual_on,
	input  logic                            pop,
	output logic                            empty,
	output logic [ADC_BITS-1:0]             median_raw,
	output logic [15:0]                     sensor_mv,
	output logic [15:0]                     pressure,
	output logic                            valve_open,
	output logic                            override_active
);

	localparam int EW = ADC_BITS + $bits(mprc_pkg::ovr_t);

	mprc_pkg::cfg_t cfg_q;

	logic          fq_push, fq_pop, fq_full, fq_empty;
	logic [EW-1:0] fq_wdata, fq_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_length        <= mprc_pkg::FRAME_LENGTH_RST;
			cfg_q.mv_per_count        <= mprc_pkg::MV_PER_COUNT_RST;
			cfg_q.sensor_offset_mv    <= mprc_pkg::OFFSET_MV_RST;
			cfg_q.psi_per_mv          <= mprc_pkg::PSI_PER_MV_RST;
			cfg_q.pressure_limit      <= mprc_pkg::LIMIT_RST;
			cfg_q.pressure_hysteresis <= mprc_pkg::HYST_RST;
			cfg_q.override_timeout    <= mprc_pkg::TIMEOUT_RST;
		end else if (cfg_write) begin
			case (mprc_pkg::cfg_reg_t'(cfg_index))
				mprc_pkg::REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data[3:0];
				mprc_pkg::REG_MV_PER_COUNT: cfg_q.mv_per_count <= cfg_data[15:0];
				mprc_pkg::REG_OFFSET_MV:    cfg_q.sensor_offset_mv <= cfg_data[15:0];
				mprc_pkg::REG_PSI_PER_MV:   cfg_q.psi_per_mv <= cfg_data[15:0];
				mprc_pkg::REG_LIMIT:        cfg_q.pressure_limit <= cfg_data[15:0];
				mprc_pkg::REG_HYSTERESIS:   cfg_q.pressure_hysteresis <= cfg_data[15:0];
				mprc_pkg::REG_TIMEOUT:      cfg_q.override_timeout <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	mprc_front #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.ADC_BITS    (ADC_BITS),
		.EW          (EW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.command    (command),
		.adc_sample (adc_sample),
		.manual_on  (manual_on),
		.q_full     (fq_full),
		.q_push     (fq_push),
		.q_data     (fq_wdata)
	);

	mprc_fifo #(
		.WIDTH (EW),
		.DEPTH (mprc_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_wdata),
		.pop    (fq_pop),
		.rdata  (fq_rdata),
		.full   (fq_full),
		.empty  (fq_empty)
	);

	mprc_back #(
		.ADC_BITS (ADC_BITS),
		.EW       (EW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (fq_empty),
		.q_data          (fq_rdata),
		.q_pop           (fq_pop),
		.pop             (pop),
		.empty           (empty),
		.median_raw      (median_raw),
		.sensor_mv       (sensor_mv),
		.pressure        (pressure),
		.valve_open      (valve_open),
		.override_active (override_active)
	);

endmodule
